>>> hw/rtl/psp_pkg.sv
// Shared types and constants of the point speed profile block.
// Depends on nothing; every other file in hw/rtl refers to it by scoped names.
`default_nettype none

package psp_pkg;

  localparam int unsigned SpeedW   = 16;
  localparam int unsigned DistW    = 16;
  localparam int unsigned AccW     = 18;              // Q16 m/s^2, up to 2.5
  localparam int unsigned SqW      = 2 * SpeedW;      // a squared speed
  localparam int unsigned ProdW    = AccW + DistW;    // acceleration times distance
  localparam int unsigned RadW     = 34;              // radicand, 1/2^20 m^2/s^2
  localparam int unsigned RootW    = RadW / 2;        // one root bit per stage
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned MidDepthDef = 4;
  localparam int unsigned OutDepthDef = 2;

  localparam logic [SpeedW-1:0] SetSpeedRst   = '0;
  localparam logic              ForwardDirRst = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSetSpeed   = CfgIdxW'(0),
    CfgForwardDir = CfgIdxW'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic [SpeedW-1:0] current_speed;
    logic [DistW-1:0]  point_distance;
    logic              path_empty;
    logic              last_point;
  } in_item_t;

  typedef struct packed {
    logic [SpeedW-1:0] point_speed;
    logic              brake_request;
    logic              last_out;
  } out_item_t;

  // A classified item as it waits between the front and the back.
  typedef struct packed {
    logic              decel;     // speed above set speed: braking branch
    logic              empty;     // empty path: brake request
    logic              last;
    logic [AccW-1:0]   acc_mag;   // magnitude of acceleration or deceleration
    logic [SpeedW-1:0] speed;
    logic [DistW-1:0]  distance;
    logic [SpeedW-1:0] set;
  } work_t;

endpackage

`default_nettype wire

>>> hw/rtl/psp_front.sv
// Front part of the point speed profile block: classifies an item and works
// out its acceleration magnitude. Depends on psp_pkg.
`default_nettype none

module psp_front (
  input  psp_pkg::in_item_t           item_i,
  input  logic [psp_pkg::SpeedW-1:0]  set_speed_i,
  input  logic                        forward_dir_i,
  output psp_pkg::work_t              work_o
);

  localparam logic [psp_pkg::AccW-1:0]   DecLimit    = 18'd163840;
  localparam logic [psp_pkg::AccW-1:0]   AccCapLow   = 18'd65536;
  localparam logic [psp_pkg::AccW-1:0]   AccCapHigh  = 18'd6554;
  // Differences at and beyond these always hit the limit or the cap.
  localparam logic [psp_pkg::SpeedW-1:0] DecClipDiff = 16'd712;
  localparam logic [psp_pkg::SpeedW-1:0] AccClipDiff = 16'd4655;
  localparam logic [21:0]                LowSpeedX36 = 22'd1536;

  logic                        decel;
  logic [psp_pkg::SpeedW-1:0]  ddiff;
  logic [psp_pkg::SpeedW-1:0]  adiff;
  logic [24:0]                 p5;
  logic [26:0]                 p25;
  logic [21:0]                 v36;
  logic [psp_pkg::AccW-1:0]    dec_mag;
  logic [psp_pkg::AccW-1:0]    acc_raw;
  logic [psp_pkg::AccW-1:0]    cap;
  logic [psp_pkg::AccW-1:0]    acc_mag;

  always_comb begin
    decel = item_i.current_speed > set_speed_i;
    ddiff = item_i.current_speed - set_speed_i;
    adiff = set_speed_i - item_i.current_speed;

    // diff*1152/5 = 230*diff + floor(2*diff/5); the fifth is a reciprocal
    // multiply that is exact for the small range left after clipping.
    p5      = 25'({ddiff[9:0], 1'b0}) * 25'd3277;
    dec_mag = (ddiff >= DecClipDiff) ? DecLimit
            : 18'(ddiff[9:0]) * 18'd230 + 18'(p5[24:14]);

    // diff*352/25 = 14*diff + floor(2*diff/25), exact likewise.
    p25     = 27'({adiff[12:0], 1'b0}) * 27'd5243;
    acc_raw = 18'(adiff[12:0]) * 18'd14 + 18'(p25[26:17]);

    v36 = 22'(item_i.current_speed) * 22'd36;
    cap = (forward_dir_i && (v36 <= LowSpeedX36)) ? AccCapLow : AccCapHigh;
    acc_mag = ((adiff >= AccClipDiff) || (acc_raw > cap)) ? cap : acc_raw;

    work_o.decel    = decel;
    work_o.empty    = item_i.path_empty;
    work_o.last     = item_i.last_point;
    work_o.acc_mag  = decel ? dec_mag : acc_mag;
    work_o.speed    = item_i.current_speed;
    work_o.distance = item_i.point_distance;
    work_o.set      = set_speed_i;
  end

endmodule

`default_nettype wire

>>> hw/rtl/psp_fifo.sv
// Small register queue used between the front and the back and at the result
// side. Depends on psp_pkg for its default depth.
`default_nettype none

module psp_fifo #(
  parameter int unsigned Depth = psp_pkg::MidDepthDef,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rd      = pop_i && !empty_o;
  // A full queue still takes an item in a cycle in which one leaves.
  assign wr      = push_i && (!full_o || rd);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd && !wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/psp_back.sv
// Back part of the point speed profile block: squares and products, the
// radicand, a pipelined square root and the final clamp. Depends on psp_pkg.
`default_nettype none

module psp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  psp_pkg::work_t     in_work_i,
  output logic               take_o,
  output logic               out_valid_o,
  output psp_pkg::out_item_t out_item_o,
  input  logic               out_ready_i
);

  localparam int unsigned RootW = psp_pkg::RootW;
  localparam int unsigned RadW  = psp_pkg::RadW;
  localparam int unsigned TrW   = RadW + 2;

  logic en;

  // Stage one: products.
  logic                        v1_q;
  psp_pkg::work_t              w1_q;
  logic [psp_pkg::ProdW-1:0]   ad_q;
  logic [psp_pkg::SqW-1:0]     vsq_q;
  logic [psp_pkg::SqW-1:0]     ssq_q;

  // Stage two: radicand.
  logic                        v2_q;
  psp_pkg::work_t              w2_q;
  logic [RadW-1:0]             y_q;
  logic [RadW-1:0]             y_d;
  logic [psp_pkg::ProdW:0]     vsq8;
  logic [psp_pkg::ProdW:0]     adx;
  logic [psp_pkg::ProdW:0]     t;
  logic [psp_pkg::SqW-1:0]     tq;

  // Root stages, one result bit each, most significant first.
  logic                        s_v_q    [RootW];
  psp_pkg::work_t              s_w_q    [RootW];
  logic [RadW-1:0]             s_rem_q  [RootW];
  logic [RootW-1:0]            s_root_q [RootW];
  logic                        in_v     [RootW];
  psp_pkg::work_t              in_w     [RootW];
  logic [RadW-1:0]             in_rem   [RootW];
  logic [RootW-1:0]            in_root  [RootW];
  logic [RadW-1:0]             nx_rem   [RootW];
  logic [RootW-1:0]            nx_root  [RootW];

  // Final stage.
  logic                        fin_v_q;
  psp_pkg::out_item_t          fin_q;
  psp_pkg::out_item_t          fin_d;
  logic [RootW-1:0]            root;
  psp_pkg::work_t              wl;
  logic [psp_pkg::SpeedW-1:0]  spd;

  assign en          = !(fin_v_q && !out_ready_i);
  assign take_o      = en && in_valid_i;
  assign out_valid_o = fin_v_q;
  assign out_item_o  = fin_q;

  always_comb begin
    vsq8 = {vsq_q, 3'b000};
    adx  = (psp_pkg::ProdW + 1)'(ad_q);
    t    = (vsq8 > adx) ? vsq8 - adx : '0;
    tq   = t[psp_pkg::ProdW:3];
    if (w1_q.decel) begin
      y_d = RadW'((tq > ssq_q) ? tq : ssq_q);
    end else begin
      y_d = RadW'(vsq_q) + RadW'(ad_q >> 3);
    end
  end

  always_comb begin
    in_v[0]    = v2_q;
    in_w[0]    = w2_q;
    in_rem[0]  = y_q;
    in_root[0] = '0;
    for (int k = 1; k < RootW; k++) begin
      in_v[k]    = s_v_q[k-1];
      in_w[k]    = s_w_q[k-1];
      in_rem[k]  = s_rem_q[k-1];
      in_root[k] = s_root_q[k-1];
    end
  end

  // Bit b of the root is kept when (root + 2^b)^2 - root^2 still fits in
  // the remainder.
  always_comb begin
    for (int k = 0; k < RootW; k++) begin
      logic [TrW-1:0] trial;
      trial = (TrW'(in_root[k]) << (RootW - k)) + (TrW'(1) << (2 * (RootW - 1 - k)));
      if ({2'b00, in_rem[k]} >= trial) begin
        nx_rem[k]  = RadW'({2'b00, in_rem[k]} - trial);
        nx_root[k] = in_root[k] | (RootW'(1) << (RootW - 1 - k));
      end else begin
        nx_rem[k]  = in_rem[k];
        nx_root[k] = in_root[k];
      end
    end
  end

  always_comb begin
    root = s_root_q[RootW-1];
    wl   = s_w_q[RootW-1];
    spd  = (root > RootW'({psp_pkg::SpeedW{1'b1}})) ? {psp_pkg::SpeedW{1'b1}}
         : root[psp_pkg::SpeedW-1:0];
    if (!wl.decel && (spd > wl.set)) begin
      spd = wl.set;
    end
    fin_d.point_speed   = wl.empty ? '0 : spd;
    fin_d.brake_request = wl.empty;
    fin_d.last_out      = wl.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      fin_v_q <= 1'b0;
      for (int k = 0; k < RootW; k++) begin
        s_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      fin_v_q <= s_v_q[RootW-1];
      for (int k = 0; k < RootW; k++) begin
        s_v_q[k] <= in_v[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q  <= in_work_i;
      ad_q  <= psp_pkg::ProdW'(in_work_i.acc_mag) * psp_pkg::ProdW'(in_work_i.distance);
      vsq_q <= psp_pkg::SqW'(in_work_i.speed) * psp_pkg::SqW'(in_work_i.speed);
      ssq_q <= psp_pkg::SqW'(in_work_i.set) * psp_pkg::SqW'(in_work_i.set);
      w2_q  <= w1_q;
      y_q   <= y_d;
      for (int k = 0; k < RootW; k++) begin
        s_w_q[k]    <= in_w[k];
        s_rem_q[k]  <= nx_rem[k];
        s_root_q[k] <= nx_root[k];
      end
      fin_q <= fin_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/point_speed_profile_top.sv
// Top level of the point speed profile block: configuration registers, front,
// middle queue, back pipeline and result queue. Depends on psp_pkg, psp_front,
// psp_fifo and psp_back.
//
//   Channel   Handshake            Payload                       Moves when
//   input     push / full          in_item_i (in_item_t)         push && !full
//   result    pop / empty          out_item_o (out_item_t)       pop && !empty
//   config    valid / ready        cfg_index_i, cfg_data_i       valid && ready
//
// The block takes one item in every cycle while full is low and gives one
// result per item. An item is classified by the front as it is pushed and
// waits in the middle queue, then passes through a 20-stage back pipeline
// (products, radicand, one stage per bit of the 17-bit square root, clamp),
// whose clamp stage hands the result on to the result queue. The square root
// pipeline sustains the one-item-per-cycle rate.
// Reset is asynchronous and active low; it empties both queues and the pipeline
// and loads the set speed with zero and the direction with forward. No clearing
// pass follows. When the result queue is full and not popped while the clamp
// stage holds a result, the back pipeline holds as a whole; the middle queue
// then fills, and full rises once it is full. Configuration writes are always
// taken; an unknown index is ignored. They are meant to happen only while the
// block is idle.
`default_nettype none

module point_speed_profile_top #(
  parameter int unsigned MidDepth = psp_pkg::MidDepthDef,
  parameter int unsigned OutDepth = psp_pkg::OutDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input queue side.
  input  logic                         push,
  output logic                         full,
  input  psp_pkg::in_item_t            in_item_i,
  // Result queue side.
  input  logic                         pop,
  output logic                         empty,
  output psp_pkg::out_item_t           out_item_o,
  // Configuration write channel.
  input  logic                         valid,
  output logic                         ready,
  input  logic [psp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [psp_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [psp_pkg::SpeedW-1:0] set_speed_q;
  logic                       forward_dir_q;

  psp_pkg::work_t             front_work;
  psp_pkg::work_t             mid_work;
  logic [$bits(psp_pkg::work_t)-1:0]    mid_data;
  logic                       mid_empty;
  logic                       back_take;

  logic                       back_valid;
  psp_pkg::out_item_t         back_item;
  logic                       out_full;
  logic                       out_ready;
  logic [$bits(psp_pkg::out_item_t)-1:0] out_data;

  // Configuration registers. The channel never stalls.
  assign ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_speed_q   <= psp_pkg::SetSpeedRst;
      forward_dir_q <= psp_pkg::ForwardDirRst;
    end else if (valid && ready) begin
      unique case (psp_pkg::cfg_reg_e'(cfg_index_i))
        psp_pkg::CfgSetSpeed: begin
          set_speed_q <= cfg_data_i[psp_pkg::SpeedW-1:0];
        end
        psp_pkg::CfgForwardDir: begin
          forward_dir_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // The front classifies an item as it is pushed; the middle queue holds it.
  psp_front u_front (
    .item_i        (in_item_i),
    .set_speed_i   (set_speed_q),
    .forward_dir_i (forward_dir_q),
    .work_o        (front_work)
  );

  psp_fifo #(
    .Depth (MidDepth),
    .Width ($bits(psp_pkg::work_t))
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .data_i  (front_work),
    .full_o  (full),
    .pop_i   (back_take),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign mid_work = psp_pkg::work_t'(mid_data);

  // The back pipeline advances whenever its last stage can hand its result on.
  psp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!mid_empty),
    .in_work_i   (mid_work),
    .take_o      (back_take),
    .out_valid_o (back_valid),
    .out_item_o  (back_item),
    .out_ready_i (out_ready)
  );

  // The result queue takes a new result in the cycle the oldest one leaves.
  assign out_ready = !out_full || (pop && !empty);

  psp_fifo #(
    .Depth (OutDepth),
    .Width ($bits(psp_pkg::out_item_t))
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid && out_ready),
    .data_i  (back_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign out_item_o = psp_pkg::out_item_t'(out_data);

endmodule

`default_nettype wire

>>> hw/rtl/psp_checker.sv
// Port-level checks of the point speed profile block and the bind that
// attaches them to point_speed_profile_top. Depends on psp_pkg.
`default_nettype none

module psp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input psp_pkg::out_item_t out_item_o
);

  // A waiting result that is not taken stays, unchanged.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed or vanished before it was taken");

  // A brake request never carries a speed.
  a_brake_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.brake_request) |-> (out_item_o.point_speed == '0))
    else $error("brake request with a nonzero speed");

  // The input side only backs up behind a result that is waiting.
  a_full_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("input full while no result is waiting");

  // Nothing is waiting right after reset.
  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queue not empty after reset");

endmodule

bind point_speed_profile_top psp_checker u_psp_checker (.*);

`default_nettype wire

>>> tb/tb_point_speed_profile_top.sv
// Self-checking testbench for point_speed_profile_top: a directed table, a pressure
// run and three random phases, each result checked against a typed value or a predictor.
// Depends on psp_pkg and point_speed_profile_top.
`default_nettype none

module tb_point_speed_profile_top;

  // Fixed-point constants of the speed plan. Accelerations are in Q16 m/s^2.
  localparam longint unsigned DecelCapQ16   = 163840;  // 2.5 m/s^2
  localparam longint unsigned AccCapLowQ16  = 65536;   // 1 m/s^2 when creeping
  localparam longint unsigned AccCapHighQ16 = 6554;    // 0.1 m/s^2
  localparam longint unsigned CreepLimitX36 = 1536;    // 36*V at 0.15/3.6 m/s

  // The block knows two registers; this index is not one of them.
  localparam logic [psp_pkg::CfgIdxW-1:0] CfgUnusedIdx = psp_pkg::CfgIdxW'(7);

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned EndSlack      = 40;   // wait after draining, longer than the block's latency
  localparam int unsigned HoldCycles    = 300;  // long receiver hold-off
  localparam int unsigned BlocksPerPhase = 6;
  localparam int unsigned ItemsPerBlock  = 88;

  // One row of the directed table. When typed is set, want is the result read off
  // the plan by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [psp_pkg::SpeedW-1:0] cruise;
    logic                       fwd;
    psp_pkg::in_item_t          stim;
    logic                       typed;
    psp_pkg::out_item_t         want;
  } dir_row_t;

  localparam int unsigned NumRows = 19;
  localparam dir_row_t DirRows [0:NumRows-1] = '{
    // Reset settings: standing still, then full speed with no distance to go.
    '{16'd0,     1'b1, '{16'd0,     16'd0,     1'b0, 1'b0}, 1'b1, '{16'd0,     1'b0, 1'b0}},
    '{16'd0,     1'b1, '{16'hFFFF,  16'd0,     1'b0, 1'b1}, 1'b1, '{16'hFFFF,  1'b0, 1'b1}},
    '{16'd0,     1'b1, '{16'hFFFF,  16'hFFFF,  1'b0, 1'b0}, 1'b0, '0},
    // Empty path: the brake request wins, speed and distance are ignored.
    '{16'd0,     1'b1, '{16'd1234,  16'hFFFF,  1'b1, 1'b1}, 1'b1, '{16'd0,     1'b1, 1'b1}},
    '{16'd0,     1'b1, '{16'hFFFF,  16'hFFFF,  1'b1, 1'b0}, 1'b1, '{16'd0,     1'b1, 1'b0}},
    // At the set speed the result is the set speed.
    '{16'd1000,  1'b1, '{16'd1000,  16'hFFFF,  1'b0, 1'b0}, 1'b1, '{16'd1000,  1'b0, 1'b0}},
    // Both sides of the creeping threshold (36*42 = 1512, 36*43 = 1548).
    '{16'd1000,  1'b1, '{16'd42,    16'hFFFF,  1'b0, 1'b0}, 1'b0, '0},
    '{16'd1000,  1'b1, '{16'd43,    16'hFFFF,  1'b0, 1'b0}, 1'b0, '0},
    '{16'd1000,  1'b1, '{16'd0,     16'hFFFF,  1'b0, 1'b1}, 1'b0, '0},
    '{16'd1200,  1'b1, '{16'd1200,  16'd0,     1'b0, 1'b0}, 1'b1, '{16'd1200,  1'b0, 1'b0}},
    // Highest set speed: capped acceleration and the top of the range.
    '{16'hFFFF,  1'b1, '{16'd0,     16'hFFFF,  1'b0, 1'b0}, 1'b0, '0},
    '{16'hFFFF,  1'b1, '{16'hFFFF,  16'hFFFF,  1'b0, 1'b1}, 1'b1, '{16'hFFFF,  1'b0, 1'b1}},
    // Reversing never uses the creeping cap.
    '{16'hFFFF,  1'b0, '{16'd0,     16'hFFFF,  1'b0, 1'b0}, 1'b0, '0},
    '{16'hFFFF,  1'b0, '{16'd42,    16'd1000,  1'b0, 1'b0}, 1'b0, '0},
    '{16'hFFFF,  1'b0, '{16'hFFFE,  16'hFFFF,  1'b0, 1'b0}, 1'b0, '0},
    // Braking far enough to go under the set speed is held at the set speed.
    '{16'd1000,  1'b0, '{16'd2000,  16'hFFFF,  1'b0, 1'b0}, 1'b1, '{16'd1000,  1'b0, 1'b0}},
    '{16'd1000,  1'b0, '{16'd1001,  16'd1,     1'b0, 1'b1}, 1'b0, '0},
    '{16'd1000,  1'b0, '{16'd40000, 16'd300,   1'b0, 1'b0}, 1'b0, '0},
    '{16'd0,     1'b0, '{16'd0,     16'd0,     1'b0, 1'b1}, 1'b1, '{16'd0,     1'b0, 1'b1}}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         push;
  logic                         full;
  psp_pkg::in_item_t            in_item;
  logic                         pop;
  logic                         empty;
  psp_pkg::out_item_t           out_item;
  logic                         valid;
  logic                         ready;
  logic [psp_pkg::CfgIdxW-1:0]  cfg_index;
  logic [psp_pkg::CfgDataW-1:0] cfg_data;

  // Side information travelling with the offered item: a hand-typed result.
  logic                         use_typed;
  psp_pkg::out_item_t           typed_want;

  // Our copy of the two registers, followed on every accepted write.
  logic [psp_pkg::SpeedW-1:0]   cfg_set_speed;
  logic                         cfg_forward;

  psp_pkg::out_item_t           planned_q[$];   // planned results still to come out
  int unsigned                  n_mismatch;
  int unsigned                  idle_cycles;
  int unsigned                  hold_left;
  int unsigned                  send_idle_pct;
  int unsigned                  recv_idle_pct;

  point_speed_profile_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item),
    .valid       (valid),
    .ready       (ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  // Floor of the square root, one result bit at a time from the top. The radicand
  // stays below 2^34, so 18 result bits are more than enough.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 17; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Planned speed at one path point under the current register copy. Squares are
  // kept in 2^-23 m^2/s^2: v^2 is V*V*8 and 2*a*d is A*D.
  function automatic psp_pkg::out_item_t plan_point_speed(psp_pkg::in_item_t it);
    psp_pkg::out_item_t r;
    longint unsigned    v;
    longint unsigned    d;
    longint unsigned    s;
    longint unsigned    rate;
    longint unsigned    cap;
    longint unsigned    sq;
    longint unsigned    x;
    longint unsigned    root;
    v = it.current_speed;
    d = it.point_distance;
    s = cfg_set_speed;
    r.last_out = it.last_point;
    if (it.path_empty) begin
      r.point_speed   = '0;
      r.brake_request = 1'b1;
      return r;
    end
    r.brake_request = 1'b0;
    if (v > s) begin
      // Braking branch: deceleration of (v - set)*3.6, at most 2.5 m/s^2, and the
      // square never drops below the set speed squared.
      rate = ((v - s) * 1152) / 5;
      if (rate > DecelCapQ16) begin
        rate = DecelCapQ16;
      end
      sq = v * v * 8;
      x  = (sq > rate * d) ? sq - rate * d : 0;
      if (x < s * s * 8) begin
        x = s * s * 8;
      end
      root = root_floor(x / 8);
    end else begin
      cap  = (cfg_forward && v * 36 <= CreepLimitX36) ? AccCapLowQ16 : AccCapHighQ16;
      rate = ((s - v) * 352) / 25;
      if (rate > cap) begin
        rate = cap;
      end
      x    = v * v * 8 + rate * d;
      root = root_floor(x / 8);
      if (root > s) begin
        root = s;
      end
    end
    if (root > 64'hFFFF) begin
      root = 64'hFFFF;
    end
    r.point_speed = root[psp_pkg::SpeedW-1:0];
    return r;
  endfunction

  // Random path point. The speed is drawn around the set speed, below or above it,
  // across the full range, near the creeping threshold, or at the extremes.
  function automatic psp_pkg::in_item_t draw_point();
    psp_pkg::in_item_t it;
    int                near;
    int unsigned       s;
    s = cfg_set_speed;
    case ($urandom_range(7))
      0, 1: it.current_speed = psp_pkg::SpeedW'($urandom_range(65535));
      2, 3: begin
        near = int'(s) + int'($urandom_range(400)) - 200;
        if (near < 0) begin
          near = 0;
        end else if (near > 65535) begin
          near = 65535;
        end
        it.current_speed = psp_pkg::SpeedW'(near);
      end
      4:    it.current_speed = psp_pkg::SpeedW'($urandom_range(60));
      5:    it.current_speed = $urandom_range(1) ? 16'hFFFF : 16'd0;
      6:    it.current_speed = psp_pkg::SpeedW'($urandom_range(s));
      default: it.current_speed = psp_pkg::SpeedW'($urandom_range(65535, s));
    endcase
    case ($urandom_range(3))
      0, 1: it.point_distance = psp_pkg::DistW'($urandom_range(65535));
      2:    it.point_distance = psp_pkg::DistW'($urandom_range(255));
      default: it.point_distance = $urandom_range(1) ? 16'hFFFF : 16'd0;
    endcase
    it.path_empty = ($urandom_range(19) == 0);
    it.last_point = ($urandom_range(7) == 0);
    return it;
  endfunction

  // Offers one item from a falling edge and returns at the falling edge after it
  // was taken. Random gaps go in front of the item.
  task automatic send_item(psp_pkg::in_item_t it, logic typed, psp_pkg::out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    in_item    <= it;
    use_typed  <= typed;
    typed_want <= want;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Stops offering and waits for every planned result to be popped.
  task automatic wait_drained();
    push <= 1'b0;
    while (planned_q.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // One register write; valid is left high for the caller to lower.
  task automatic write_reg(logic [psp_pkg::CfgIdxW-1:0] idx,
                           logic [psp_pkg::CfgDataW-1:0] data);
    valid     <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!ready);
    @(negedge clk);
  endtask

  // New settings, written only once the block has emptied out.
  task automatic apply_setting(logic [psp_pkg::SpeedW-1:0] cruise, logic fwd, logic stray);
    wait_drained();
    if (stray) begin
      write_reg(CfgUnusedIdx, psp_pkg::CfgDataW'($urandom_range(65535)));
    end
    write_reg(psp_pkg::CfgSetSpeed, cruise);
    write_reg(psp_pkg::CfgForwardDir, psp_pkg::CfgDataW'(fwd));
    valid <= 1'b0;
  endtask

  // The receiver pops at random and, when asked, holds off for a long stretch
  // that it counts down itself.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Everything that moves is seen here at the rising edge: register writes update
  // our copy, accepted items are planned, and popped results are checked against
  // the oldest plan. The watchdog counts edges at which nothing moves at all.
  always @(posedge clk) begin
    if (rst_n) begin
      if (valid && ready) begin
        case (cfg_index)
          psp_pkg::CfgSetSpeed:   cfg_set_speed = cfg_data[psp_pkg::SpeedW-1:0];
          psp_pkg::CfgForwardDir: cfg_forward   = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) begin
        planned_q.insert(planned_q.size(),
                         use_typed ? typed_want : plan_point_speed(in_item));
      end
      if (pop && !empty) begin
        if (planned_q.size() == 0) begin
          $error("result with no item waiting: point_speed %0d", out_item.point_speed);
          n_mismatch++;
        end else begin
          automatic psp_pkg::out_item_t want = planned_q.pop_front();
          if (out_item.point_speed !== want.point_speed) begin
            $error("point_speed expected %0d actual %0d",
                   want.point_speed, out_item.point_speed);
            n_mismatch++;
          end
          if (out_item.brake_request !== want.brake_request) begin
            $error("brake_request expected %0b actual %0b",
                   want.brake_request, out_item.brake_request);
            n_mismatch++;
          end
          if (out_item.last_out !== want.last_out) begin
            $error("last_out expected %0b actual %0b", want.last_out, out_item.last_out);
            n_mismatch++;
          end
        end
      end
      if ((push && !full) || (pop && !empty) || (valid && ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
          $display("point_speed_profile_top regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    push          = 1'b0;
    in_item       = '0;
    pop           = 1'b0;
    valid         = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    use_typed     = 1'b0;
    typed_want    = '0;
    cfg_set_speed = psp_pkg::SetSpeedRst;
    cfg_forward   = psp_pkg::ForwardDirRst;
    n_mismatch    = 0;
    idle_cycles   = 0;
    hold_left     = 0;
    send_idle_pct = 10;
    recv_idle_pct = 62;

    // Reset is applied once and released on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Rows that need other settings first let the block empty out
    // and then rewrite both registers.
    for (int r = 0; r < NumRows; r++) begin
      if (DirRows[r].cruise != cfg_set_speed || DirRows[r].fwd != cfg_forward) begin
        apply_setting(DirRows[r].cruise, DirRows[r].fwd, 1'b0);
      end
      send_item(DirRows[r].stim, DirRows[r].typed, DirRows[r].want);
    end

    // Pressure: the receiver holds off while items keep coming back to back, so the
    // result queue, the pipeline and the middle queue fill and full rises. Then
    // the sender pauses until every planned result has come out.
    apply_setting(16'd3000, 1'b1, 1'b1);
    @(posedge clk);
    hold_left = HoldCycles;
    @(negedge clk);
    send_idle_pct = 0;
    repeat (60) send_item(draw_point(), 1'b0, '0);
    wait_drained();

    // Random phases: the sender idles lightly and the receiver heavily, then the
    // other way round, then neither. Settings change every block of items.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 10 : 0;
      for (int blk = 0; blk < BlocksPerPhase; blk++) begin
        automatic logic [psp_pkg::SpeedW-1:0] cruise;
        case ($urandom_range(5))
          0:       cruise = '0;
          1:       cruise = '1;
          2, 3:    cruise = psp_pkg::SpeedW'($urandom_range(65535));
          4:       cruise = psp_pkg::SpeedW'($urandom_range(2000));
          default: cruise = psp_pkg::SpeedW'($urandom_range(30000, 10000));
        endcase
        apply_setting(cruise, 1'($urandom_range(1)), blk == 0);
        repeat (ItemsPerBlock) send_item(draw_point(), 1'b0, '0);
      end
    end

    // Let everything drain, then give a stray extra result a chance to show up.
    wait_drained();
    repeat (EndSlack) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("point_speed_profile_top regression: pass");
    end else begin
      $display("point_speed_profile_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
